@@ hdl/lavm_pkg.sv @@
// Shared constants, types and rounding helpers for the look-at view matrix block.
package lavm_pkg;

   // Pipeline geometry: stage 0 is the request register, the matrix sits in the last stage
   localparam int unsigned PIPE_DEPTH = 42;
   localparam int unsigned ST_MAT     = 41;
   localparam int unsigned ST_EYE     = 37;
   localparam int unsigned NORM_LAT   = 15;

   // Column codes
   localparam logic [1:0] COL0 = 2'd0;
   localparam logic [1:0] COL1 = 2'd1;
   localparam logic [1:0] COL2 = 2'd2;
   localparam logic [1:0] COL3 = 2'd3;

   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   // Short-vector limits on the sum of squares (length 0.0001 in Q16.16 and Q2.30)
   localparam logic [35:0] THR_Q16 = 36'd43;
   localparam logic [35:0] THR_Q30 = 36'd11529215047;

   typedef logic [2:0][32:0] vec33_type;
   typedef logic [2:0][31:0] vec32_type;

   // Round half away from zero while dropping sh fraction bits (sh >= 1)
   function automatic logic signed [66:0] rnd_away(input logic signed [66:0] x,
                                                   input int unsigned sh);
      logic signed [66:0] half;
      logic signed [66:0] sum;
      half = 67'sd1 <<< (sh - 1);
      sum  = x[66] ? (x + half - 67'sd1) : (x + half);
      return sum >>> sh;
   endfunction

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
      logic signed [31:0] r;
      if (x > 67'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -67'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = $signed(x[31:0]);
      end
      return r;
   endfunction

endpackage

@@ hdl/lavm_norm.sv @@
// Pipelined three-component vector normaliser: scale, square root and divide stages.
module lavm_norm (
   input  logic                clock,
   input  logic                en,
   input  logic                q16_mode,
   input  lavm_pkg::vec33_type vec_in,
   output lavm_pkg::vec32_type vec_out
);
   import lavm_pkg::*;

   typedef struct packed {
      logic            is_short;
      logic [2:0]      neg;
      logic [2:0][31:0] shortv;
   } side_type;

   typedef struct packed {
      logic [63:0] x;
      logic [35:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [30:0] low;
      logic [30:0] quo;
   } div_type;

   typedef div_type [2:0] div3_type;

   // Eight digit steps of the bitwise square root
   function automatic sqrt_type sqrt_steps(input sqrt_type st);
      sqrt_type    r;
      logic [35:0] trial;
      r = st;
      for (int unsigned k = 0; k < 8; k++) begin
         r.rem = {r.rem[33:0], r.x[63:62]};
         r.x   = {r.x[61:0], 2'b00};
         trial = {2'b00, r.root, 2'b01};
         if (r.rem >= trial) begin
            r.rem  = r.rem - trial;
            r.root = {r.root[30:0], 1'b1};
         end else begin
            r.root = {r.root[30:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Up to eight restoring division steps
   function automatic div_type div_steps(input div_type st, input logic [31:0] len,
                                         input int unsigned n);
      div_type r;
      r = st;
      for (int unsigned k = 0; k < 8; k++) begin
         if (k < n) begin
            r.rem = {r.rem[32:0], r.low[30]};
            r.low = {r.low[29:0], 1'b0};
            if (r.rem >= {2'b00, len}) begin
               r.rem = r.rem - {2'b00, len};
               r.quo = {r.quo[29:0], 1'b1};
            end else begin
               r.quo = {r.quo[29:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

   // Position of the leading one
   function automatic logic [5:0] msb_pos(input logic [32:0] m);
      logic [5:0] pos;
      pos = '0;
      for (int unsigned k = 0; k < 33; k++) begin
         if (m[k]) pos = 6'(k);
      end
      return pos;
   endfunction

   logic [2:0][32:0] s1_mag_ff;
   logic [32:0]      s1_mor_ff;
   logic [2:0][32:0] s2_mag_ff;
   logic [5:0]       s2_lead_ff;
   side_type         side_ff [1:14];
   logic [2:0][30:0] mg_ff   [3:9];
   logic [2:0][61:0] sq4_ff;
   logic [63:0]      sum5_ff;
   sqrt_type         rt_ff   [6:9];
   div3_type         dv_ff   [10:14];
   logic [31:0]      len_ff  [10:13];
   vec32_type        out_ff;

   logic [2:0][32:0] mag_in;
   side_type         side1_in;
   logic             small_in;
   logic [35:0]      sqsum;
   logic             fits;
   logic [2:0][30:0] mg_in;
   logic [32:0]      mgs;
   div3_type         dv_in;
   logic [61:0]      numer;

   // Stage 1: magnitudes, signs and the unnormalised fallback
   always_comb begin
      side1_in.is_short = 1'b0;
      for (int unsigned i = 0; i < 3; i++) begin
         mag_in[i] = vec_in[i][32] ? (33'd0 - vec_in[i]) : vec_in[i];
         side1_in.neg[i] = vec_in[i][32];
         side1_in.shortv[i] = q16_mode ? {vec_in[i][17:0], 14'd0} : vec_in[i][31:0];
      end
   end

   // Stage 2: short-vector test on narrow squares
   always_comb begin
      sqsum = '0;
      fits  = 1'b1;
      for (int unsigned i = 0; i < 3; i++) begin
         fits  = fits & (s1_mag_ff[i][32:17] == '0);
         sqsum = sqsum + 36'(s1_mag_ff[i][16:0]) * 36'(s1_mag_ff[i][16:0]);
      end
      small_in = fits && (sqsum < (q16_mode ? THR_Q16 : THR_Q30));
   end

   // Stage 3: scale so the largest magnitude lands in [2^30, 2^31)
   always_comb begin
      mgs = '0;
      for (int unsigned i = 0; i < 3; i++) begin
         if (s2_lead_ff >= 6'd31) begin
            mgs = s2_mag_ff[i] >> (s2_lead_ff - 6'd30);
         end else begin
            mgs = s2_mag_ff[i] << (6'd30 - s2_lead_ff);
         end
         mg_in[i] = mgs[30:0];
      end
   end

   // Stage 10: rounded numerators (magnitude in Q30 plus half the length)
   always_comb begin
      numer = '0;
      for (int unsigned i = 0; i < 3; i++) begin
         numer = {1'b0, mg_ff[9][i], 30'd0} + 62'(rt_ff[9].root >> 1);
         dv_in[i].rem = {3'b000, numer[61:31]};
         dv_in[i].low = numer[30:0];
         dv_in[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mag_ff  <= mag_in;
         s1_mor_ff  <= mag_in[0] | mag_in[1] | mag_in[2];
         side_ff[1] <= side1_in;

         s2_mag_ff  <= s1_mag_ff;
         s2_lead_ff <= msb_pos(s1_mor_ff);
         side_ff[2] <= {small_in, side_ff[1].neg, side_ff[1].shortv};
         for (int unsigned k = 3; k < 15; k++) begin
            side_ff[k] <= side_ff[k-1];
         end

         mg_ff[3] <= mg_in;
         for (int unsigned k = 4; k < 10; k++) begin
            mg_ff[k] <= mg_ff[k-1];
         end

         // Squares, then their sum
         for (int unsigned i = 0; i < 3; i++) begin
            sq4_ff[i] <= 62'(mg_ff[3][i]) * 62'(mg_ff[3][i]);
         end
         sum5_ff <= 64'(sq4_ff[0]) + 64'(sq4_ff[1]) + 64'(sq4_ff[2]);

         // Square root, eight digits a stage
         rt_ff[6] <= sqrt_steps({sum5_ff, 36'd0, 32'd0});
         for (int unsigned k = 7; k < 10; k++) begin
            rt_ff[k] <= sqrt_steps(rt_ff[k-1]);
         end

         // Division, 31 quotient bits over four stages
         dv_ff[10]  <= dv_in;
         len_ff[10] <= rt_ff[9].root;
         for (int unsigned k = 11; k < 14; k++) begin
            len_ff[k] <= len_ff[k-1];
         end
         for (int unsigned k = 11; k < 15; k++) begin
            for (int unsigned i = 0; i < 3; i++) begin
               dv_ff[k][i] <= div_steps(dv_ff[k-1][i], len_ff[k-1], (k == 14) ? 7 : 8);
            end
         end

         // Sign back on, or pass a short vector through
         for (int unsigned i = 0; i < 3; i++) begin
            if (side_ff[14].is_short) begin
               out_ff[i] <= side_ff[14].shortv[i];
            end else if (side_ff[14].neg[i]) begin
               out_ff[i] <= 32'd0 - {1'b0, dv_ff[14][i].quo};
            end else begin
               out_ff[i] <= {1'b0, dv_ff[14][i].quo};
            end
         end
      end
   end

   assign vec_out = out_ff;

endmodule

@@ hdl/look_at_view_matrix.sv @@
// The first column leaves after pipeline stages 0 to 41 and the serialiser register, then one
// a cycle while rsp_ready holds; a busy serialiser reloads only as its last column is taken;
//   the 42-stage pipeline itself takes a request every cycle and stalls as a whole.
// Normalisation uses three 15-stage units (scale, square root, divide).
// Reset clears the valid bits and the serialiser only; there is no clearing pass.
module look_at_view_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_upvec_x,
   input  logic signed [31:0] req_upvec_y,
   input  logic signed [31:0] req_upvec_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_column_index,
   output logic signed [31:0] rsp_entry_row0,
   output logic signed [31:0] rsp_entry_row1,
   output logic signed [31:0] rsp_entry_row2,
   output logic signed [31:0] rsp_entry_row3,
   output logic               rsp_last_column
);
   import lavm_pkg::*;

   // Cross-product partial products: a1b2, a2b1, a2b0, a0b2, a0b1, a1b0
   function automatic logic [5:0][63:0] cross_prods(input vec32_type a, input vec32_type b);
      logic [5:0][63:0] p;
      p[0] = 64'($signed(a[1])) * 64'($signed(b[2]));
      p[1] = 64'($signed(a[2])) * 64'($signed(b[1]));
      p[2] = 64'($signed(a[2])) * 64'($signed(b[0]));
      p[3] = 64'($signed(a[0])) * 64'($signed(b[2]));
      p[4] = 64'($signed(a[0])) * 64'($signed(b[1]));
      p[5] = 64'($signed(a[1])) * 64'($signed(b[0]));
      return p;
   endfunction

   logic [PIPE_DEPTH-1:0] vld_ff;
   logic adv;
   logic load;
   logic ser_last_go;

   vec32_type eye_dl_ff [0:ST_EYE];
   vec32_type tgt_ff;
   vec32_type upv_ff;
   vec33_type fr_ff;
   vec33_type upr_ff;
   vec32_type f_norm;
   vec32_type up_norm;
   vec32_type s_norm;
   logic [5:0][63:0] cp1_ff;
   logic [2:0][64:0] cd1_ff;
   vec33_type        sr_ff;
   vec32_type        f_dl_ff [17:37];
   vec32_type        s_dl_ff [35:37];
   logic [5:0][63:0] cp2_ff;
   logic [2:0][64:0] cd2_ff;
   vec33_type        u_ff;
   logic [2:0][63:0] pse_ff;
   logic [2:0][64:0] pue_ff;
   logic [2:0][63:0] pfe_ff;
   logic [2:0][2:0][19:0] ent_ff [38:40];
   logic [66:0] ds_ff;
   logic [66:0] du_ff;
   logic [66:0] df_ff;
   logic [36:0] ts_ff;
   logic [36:0] tu_ff;
   logic [36:0] tf_ff;
   logic [3:0][2:0][31:0] mat_ff;
   logic [3:0][2:0][31:0] ser_mat_ff;
   logic ser_valid_ff;
   logic [1:0] col_ff;

   vec33_type fr_in;
   vec33_type upr_in;
   vec33_type sr_in;
   vec33_type u_in;
   logic [2:0][2:0][19:0] ent_in;
   logic [36:0] ts_in;
   logic [36:0] tu_in;
   logic [36:0] tf_in;
   logic [3:0][2:0][31:0] mat_in;
   logic signed [66:0] rtmp;
   logic signed [66:0] etmp;

   // Handshake and stall control
   assign ser_last_go = ser_valid_ff && rsp_ready && (col_ff == COL3);
   assign load        = vld_ff[ST_MAT] && (!ser_valid_ff || ser_last_go);
   assign adv         = !vld_ff[ST_MAT] || load;
   assign req_ready   = adv;

   // Forward vector and widened up vector
   always_comb begin
      for (int unsigned i = 0; i < 3; i++) begin
         fr_in[i]  = 33'($signed(tgt_ff[i])) - 33'($signed(eye_dl_ff[0][i]));
         upr_in[i] = 33'($signed(upv_ff[i]));
      end
   end

   // Rounding of both cross products back to Q30
   always_comb begin
      rtmp = '0;
      for (int unsigned i = 0; i < 3; i++) begin
         rtmp     = rnd_away(67'($signed(cd1_ff[i])), 30);
         sr_in[i] = rtmp[32:0];
         rtmp     = rnd_away(67'($signed(cd2_ff[i])), 30);
         u_in[i]  = rtmp[32:0];
      end
   end

   // Matrix entries rounded to Q16.16, and translation terms
   always_comb begin
      etmp = '0;
      for (int unsigned i = 0; i < 3; i++) begin
         etmp = rnd_away(67'($signed(s_dl_ff[37][i])), 14);
         ent_in[0][i] = etmp[19:0];
         etmp = rnd_away(67'($signed(u_ff[i])), 14);
         ent_in[1][i] = etmp[19:0];
         etmp = rnd_away(67'($signed(f_dl_ff[37][i])), 14);
         ent_in[2][i] = etmp[19:0];
      end
      etmp  = rnd_away($signed(ds_ff), 30);
      ts_in = etmp[36:0];
      etmp  = rnd_away($signed(du_ff), 30);
      tu_in = etmp[36:0];
      etmp  = rnd_away($signed(df_ff), 30);
      tf_in = etmp[36:0];
   end

   // Saturated column-major matrix
   always_comb begin
      for (int unsigned k = 0; k < 3; k++) begin
         mat_in[k][0] = sat32(67'($signed(ent_ff[40][0][k])));
         mat_in[k][1] = sat32(67'($signed(ent_ff[40][1][k])));
         mat_in[k][2] = sat32(67'sd0 - 67'($signed(ent_ff[40][2][k])));
      end
      mat_in[3][0] = sat32(67'sd0 - 67'($signed(ts_ff)));
      mat_in[3][1] = sat32(67'sd0 - 67'($signed(tu_ff)));
      mat_in[3][2] = sat32(67'($signed(tf_ff)));
   end

   // Normalisers: forward and up from stage 1, side vector from stage 19
   lavm_norm u_norm_f (
      .clock    (clock),
      .en       (adv),
      .q16_mode (1'b1),
      .vec_in   (fr_ff),
      .vec_out  (f_norm)
   );

   lavm_norm u_norm_up (
      .clock    (clock),
      .en       (adv),
      .q16_mode (1'b1),
      .vec_in   (upr_ff),
      .vec_out  (up_norm)
   );

   lavm_norm u_norm_s (
      .clock    (clock),
      .en       (adv),
      .q16_mode (1'b0),
      .vec_in   (sr_ff),
      .vec_out  (s_norm)
   );

   // Valid bits and output serialiser
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         ser_valid_ff <= 1'b0;
         col_ff       <= COL0;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         end
         if (load) begin
            ser_valid_ff <= 1'b1;
            col_ff       <= COL0;
         end else if (ser_valid_ff && rsp_ready) begin
            if (col_ff == COL3) begin
               ser_valid_ff <= 1'b0;
            end else begin
               col_ff <= col_ff + 2'd1;
            end
         end
      end
   end

   // Datapath registers, all held on a stall
   always_ff @(posedge clock) begin
      if (adv) begin
         eye_dl_ff[0] <= {req_eye_z, req_eye_y, req_eye_x};
         tgt_ff       <= {req_target_z, req_target_y, req_target_x};
         upv_ff       <= {req_upvec_z, req_upvec_y, req_upvec_x};
         for (int unsigned k = 1; k <= ST_EYE; k++) begin
            eye_dl_ff[k] <= eye_dl_ff[k-1];
         end
         fr_ff  <= fr_in;
         upr_ff <= upr_in;

         // side = f x up
         cp1_ff <= cross_prods(f_norm, up_norm);
         for (int unsigned i = 0; i < 3; i++) begin
            cd1_ff[i] <= 65'($signed(cp1_ff[2*i])) - 65'($signed(cp1_ff[2*i+1]));
         end
         sr_ff <= sr_in;

         f_dl_ff[17] <= f_norm;
         for (int unsigned k = 18; k < 38; k++) begin
            f_dl_ff[k] <= f_dl_ff[k-1];
         end
         s_dl_ff[35] <= s_norm;
         for (int unsigned k = 36; k < 38; k++) begin
            s_dl_ff[k] <= s_dl_ff[k-1];
         end

         // true up = s x f
         cp2_ff <= cross_prods(s_norm, f_dl_ff[34]);
         for (int unsigned i = 0; i < 3; i++) begin
            cd2_ff[i] <= 65'($signed(cp2_ff[2*i])) - 65'($signed(cp2_ff[2*i+1]));
         end
         u_ff <= u_in;

         // Dot products with the eye
         for (int unsigned i = 0; i < 3; i++) begin
            pse_ff[i] <= 64'($signed(s_dl_ff[37][i])) * 64'($signed(eye_dl_ff[37][i]));
            pue_ff[i] <= 65'($signed(u_ff[i])) * 65'($signed(eye_dl_ff[37][i]));
            pfe_ff[i] <= 64'($signed(f_dl_ff[37][i])) * 64'($signed(eye_dl_ff[37][i]));
         end
         ent_ff[38] <= ent_in;
         ds_ff <= 67'($signed(pse_ff[0])) + 67'($signed(pse_ff[1])) + 67'($signed(pse_ff[2]));
         du_ff <= 67'($signed(pue_ff[0])) + 67'($signed(pue_ff[1])) + 67'($signed(pue_ff[2]));
         df_ff <= 67'($signed(pfe_ff[0])) + 67'($signed(pfe_ff[1])) + 67'($signed(pfe_ff[2]));
         ent_ff[39] <= ent_ff[38];
         ts_ff <= ts_in;
         tu_ff <= tu_in;
         tf_ff <= tf_in;
         ent_ff[40] <= ent_ff[39];
         mat_ff <= mat_in;
      end
      if (load) begin
         ser_mat_ff <= mat_ff;
      end
   end

   // Column select
   always_comb begin
      case (col_ff)
         COL0: begin
            rsp_entry_row0 = ser_mat_ff[0][0];
            rsp_entry_row1 = ser_mat_ff[0][1];
            rsp_entry_row2 = ser_mat_ff[0][2];
         end
         COL1: begin
            rsp_entry_row0 = ser_mat_ff[1][0];
            rsp_entry_row1 = ser_mat_ff[1][1];
            rsp_entry_row2 = ser_mat_ff[1][2];
         end
         COL2: begin
            rsp_entry_row0 = ser_mat_ff[2][0];
            rsp_entry_row1 = ser_mat_ff[2][1];
            rsp_entry_row2 = ser_mat_ff[2][2];
         end
         default: begin
            rsp_entry_row0 = ser_mat_ff[3][0];
            rsp_entry_row1 = ser_mat_ff[3][1];
            rsp_entry_row2 = ser_mat_ff[3][2];
         end
      endcase
   end

   assign rsp_valid        = ser_valid_ff;
   assign rsp_column_index = col_ff;
   assign rsp_last_column  = (col_ff == COL3);
   assign rsp_entry_row3   = (col_ff == COL3) ? ONE_Q16 : 32'sd0;

`ifndef SYNTHESIS
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved while stalled");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (vld_ff[ST_MAT] && ser_valid_ff))
      else $error("request refused with room in the pipeline");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && (col_ff != COL3)) |=>
         (rsp_valid && (rsp_column_index == $past(col_ff) + 2'd1)))
      else $error("column sequence broken");

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid && (col_ff == COL0)))
      else $error("new matrix does not start at column 0");
`endif

endmodule
